// File: hdl/nsf_pkg.sv
`timescale 1ns / 1ps
package nsf_pkg;

  localparam logic [1:0] MODE_COLLAGEN = 2'd0;
  localparam logic [1:0] MODE_CIRC     = 2'd1;
  localparam logic [1:0] MODE_RADIAL   = 2'd2;
  localparam logic [1:0] MODE_COMP     = 2'd3;

  localparam logic [28:0] COEF_A     = 29'd304309862;
  localparam logic [28:0] COEF_ETA   = 29'd325000000;
  localparam logic [29:0] RATE_B0    = 30'd838261853;
  localparam logic [29:0] RATE_B1    = 30'd963960269;
  localparam logic [29:0] RATE_B2    = 30'd375762664;
  localparam logic signed [31:0] KNEE_Q28 = 32'sd38923141;
  localparam logic [31:0] OFFSET_Q28 = 32'd33554432;
  localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
  localparam logic [29:0] LN2_Q30    = 30'd744261118;
  localparam logic [31:0] Q28_ONE    = 32'd268435456;
  localparam logic [31:0] Q30_ONE    = 32'd1073741824;
  localparam logic [31:0] STRAIN_MAX = 32'h7FFF_FFFF;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_ZERO = 2'd0,
    KIND_NEG  = 2'd1,
    KIND_LIN  = 2'd2,
    KIND_EXP  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic              bad;
    logic              clip_sat;
    logic [1:0]        mode;
    logic [31:0]       kappa;
    logic signed [31:0] strain;
  } item_t;

  function automatic logic [31:0] pow2_quarter(input logic [1:0] idx);
    logic [31:0] v;
    case (idx)
      2'd0: v = 32'd1073741824;
      2'd1: v = 32'd1276901417;
      2'd2: v = 32'd1518500250;
      2'd3: v = 32'd1805811301;
      default: v = 32'd1073741824;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/nsf_front.sv
`timescale 1ns / 1ps
module nsf_front #(
  parameter int LW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      in_mode,
  input  logic [31:0]     in_length,
  input  logic [31:0]     in_rest_length,
  input  logic [31:0]     in_stiffness,
  output logic            busy,
  output logic            push,
  output nsf_pkg::item_t  item,
  input  logic            full
);

  localparam int STEPS = 32;

  typedef struct packed {
    logic          vld;
    logic [1:0]    mode;
    logic [31:0]   kappa;
    logic          bad;
    logic          clip;
    logic [LW-1:0] rest;
    logic [LW-1:0] rem;
    logic [31:0]   quo;
    logic [3:0]    lo;
  } div_t;

  div_t stg_r   [STEPS+1];
  div_t stg_nxt [STEPS+1];

  logic          adv;
  logic [LW-1:0] len;
  logic [LW-1:0] rest;
  logic [LW+3:0] nine;

  assign adv  = !full;
  assign busy = full;
  assign len  = in_length[LW-1:0];
  assign rest = in_rest_length[LW-1:0];
  assign nine = (LW+4)'({rest, 3'b000}) + (LW+4)'(rest);

  always_comb begin
    logic [LW:0] tr;
    logic        ge;
    stg_nxt[0].vld   = start;
    stg_nxt[0].mode  = in_mode;
    stg_nxt[0].kappa = in_stiffness;
    stg_nxt[0].bad   = (rest == '0);
    stg_nxt[0].clip  = ((LW+4)'(len) >= nine);
    stg_nxt[0].rest  = rest;
    stg_nxt[0].rem   = len >> 4;
    stg_nxt[0].quo   = '0;
    stg_nxt[0].lo    = len[3:0];
    for (int j = 0; j < STEPS; j++) begin
      tr = {stg_r[j].rem, stg_r[j].lo[3]};
      ge = (tr >= {1'b0, stg_r[j].rest});
      stg_nxt[j+1]      = stg_r[j];
      stg_nxt[j+1].rem  = ge ? LW'(tr - {1'b0, stg_r[j].rest}) : tr[LW-1:0];
      stg_nxt[j+1].quo  = {stg_r[j].quo[30:0], ge};
      stg_nxt[j+1].lo   = {stg_r[j].lo[2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= STEPS; j++) stg_r[j].vld <= 1'b0;
    end else if (adv) begin
      for (int j = 0; j <= STEPS; j++) stg_r[j] <= stg_nxt[j];
    end
  end

  // classify the finished strain
  always_comb begin
    logic signed [31:0] e;
    div_t d;
    d = stg_r[STEPS];
    e = d.clip ? nsf_pkg::STRAIN_MAX : (d.quo - nsf_pkg::Q28_ONE);
    item.bad      = d.bad;
    item.mode     = d.mode;
    item.kappa    = d.kappa;
    item.strain   = e;
    item.clip_sat = d.clip && !d.bad && (d.mode != nsf_pkg::MODE_COMP) && (d.kappa != '0);
    if (d.bad) begin
      item.kind = nsf_pkg::KIND_ZERO;
    end else if (d.mode == nsf_pkg::MODE_COMP) begin
      item.kind = (e < 0) ? nsf_pkg::KIND_NEG : nsf_pkg::KIND_ZERO;
    end else if (d.mode == nsf_pkg::MODE_COLLAGEN && e > nsf_pkg::KNEE_Q28) begin
      item.kind = nsf_pkg::KIND_LIN;
    end else if (e > 0) begin
      item.kind = nsf_pkg::KIND_EXP;
    end else begin
      item.kind = nsf_pkg::KIND_ZERO;
    end
  end

  assign push = adv && stg_r[STEPS].vld;

endmodule

// File: hdl/nsf_queue.sv
`timescale 1ns / 1ps
module nsf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nsf_pkg::item_t din,
  input  logic           pop,
  output nsf_pkg::item_t dout,
  output logic           empty,
  output logic           full
);

  localparam int DEPTH = nsf_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  nsf_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [AW:0]    cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];
  assign cnt_nxt = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("item pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("item popped from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
      cnt_r <= (AW+1)'(DEPTH) && (cnt_r == (AW+1)'(AW'(wr_ptr_r - rd_ptr_r)) || full))
    else $error("queue count out of step with pointers");

endmodule

// File: hdl/nsf_back.sv
`timescale 1ns / 1ps
module nsf_back #(
  parameter int FW = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  nsf_pkg::item_t item,
  input  logic           item_vld,
  output logic           out_valid,
  output logic [63:0]    out_force_res,
  output logic           out_saturated,
  output logic           out_bad_rest
);

  localparam int NST = 23;
  localparam int SW  = 156;
  localparam int MW  = SW - 20;
  localparam logic [MW-1:0] NEG_LIM = MW'(1) << (FW - 1);
  localparam logic [MW-1:0] POS_LIM = NEG_LIM - MW'(1);

  typedef struct packed {
    logic               vld;
    nsf_pkg::kind_t     kind;
    logic               bad;
    logic               clip_sat;
    logic [1:0]         mode;
    logic               kappa_nz;
    logic               ovf;
    logic [60:0]        a;
    logic [31:0]        b;
    logic [5:0]         k;
    logic [1:0]         idx;
    logic [27:0]        z;
  } car_t;

  car_t cr_r   [1:NST];
  car_t cr_nxt [1:NST];

  logic [60:0]  xp_r;
  logic [62:0]  ylo_r;
  logic [35:0]  yhi_r;
  logic [25:0]  g_r;
  logic [29:0]  t_r [7];
  logic [31:0]  p_r [7];
  logic [31:0]  m_r;
  logic [63:0]  pl_r;
  logic [60:0]  ph_r;
  logic [92:0]  pw_r;
  logic [90:0]  sub_r, sub2_r;
  logic [SW-1:0] shv_r, w_r;

  logic         out_valid_r, out_sat_r, out_bad_r;
  logic [63:0]  out_force_r;
  logic [63:0]  out_force_r_nxt;
  logic         out_sat_nxt;

  logic [29:0]  rate;
  logic [28:0]  cst;
  logic [31:0]  eu;
  logic [36:0]  xv;
  logic [67:0]  ysum;
  logic [37:0]  y;
  logic [57:0]  zp;
  logic [63:0]  mp;
  logic [31:0]  bsel;

  assign eu = item.strain;

  always_comb begin
    case (item.mode)
      nsf_pkg::MODE_COLLAGEN: rate = nsf_pkg::RATE_B0;
      nsf_pkg::MODE_CIRC:     rate = nsf_pkg::RATE_B1;
      default:                rate = nsf_pkg::RATE_B2;
    endcase
    if (item.mode != nsf_pkg::MODE_COLLAGEN) begin
      cst = 29'd1;
    end else if (item.kind == nsf_pkg::KIND_LIN) begin
      cst = nsf_pkg::COEF_ETA;
    end else begin
      cst = nsf_pkg::COEF_A;
    end
  end

  assign xv   = xp_r[60:24];
  assign ysum = 68'(ylo_r) + (68'(yhi_r) << 32);
  assign y    = ysum[67:30];
  assign zp   = 58'({g_r, 2'b00}) * 58'(nsf_pkg::LN2_Q30);
  assign mp   = 64'(nsf_pkg::pow2_quarter(cr_r[18].idx)) * 64'(p_r[6]);
  assign bsel = (cr_r[19].kind == nsf_pkg::KIND_EXP) ? m_r : cr_r[19].b;

  always_comb begin
    cr_nxt[1].vld      = item_vld;
    cr_nxt[1].kind     = item.kind;
    cr_nxt[1].bad      = item.bad;
    cr_nxt[1].clip_sat = item.clip_sat;
    cr_nxt[1].mode     = item.mode;
    cr_nxt[1].kappa_nz = (item.kappa != '0);
    cr_nxt[1].ovf      = 1'b0;
    cr_nxt[1].a        = 61'(item.kappa) * 61'(cst);
    cr_nxt[1].b        = (item.kind == nsf_pkg::KIND_LIN) ? eu - nsf_pkg::OFFSET_Q28
                                                          : 32'd0 - eu;
    cr_nxt[1].k        = '0;
    cr_nxt[1].idx      = '0;
    cr_nxt[1].z        = '0;
    for (int s = 2; s <= NST; s++) cr_nxt[s] = cr_r[s-1];
    cr_nxt[3].ovf = (y[37:34] != '0);
    cr_nxt[3].k   = y[33:28];
    cr_nxt[3].idx = y[27:26];
    cr_nxt[4].z   = zp[57:30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= NST; s++) cr_r[s].vld <= 1'b0;
    end else begin
      for (int s = 1; s <= NST; s++) cr_r[s] <= cr_nxt[s];
    end
  end

  always_ff @(posedge clk) begin
    xp_r  <= 61'(eu[30:0]) * 61'(rate);
    ylo_r <= 63'(xv[31:0]) * 63'(nsf_pkg::LOG2E_Q30);
    yhi_r <= 36'(xv[36:32]) * 36'(nsf_pkg::LOG2E_Q30);
    g_r   <= y[25:0];
  end

  // Horner steps, n = 7 down to 1
  for (genvar h = 0; h < 7; h++) begin : g_horn
    localparam int unsigned N = 7 - h;
    localparam logic [32:0] RCP = 33'((64'd4294967296 + 64'(N) - 64'd1) / 64'(N));
    logic [31:0] pin;
    logic [59:0] tp;
    logic [62:0] qp;
    if (h == 0) begin : g_first
      assign pin = nsf_pkg::Q30_ONE;
    end else begin : g_rest
      assign pin = p_r[h-1];
    end
    assign tp = 60'(cr_r[4+2*h].z) * 60'(pin);
    assign qp = 63'(t_r[h]) * 63'(RCP);
    always_ff @(posedge clk) begin
      t_r[h] <= tp[59:30];
      p_r[h] <= nsf_pkg::Q30_ONE + 32'(qp[62:32]);
    end
  end

  always_ff @(posedge clk) begin
    m_r    <= mp[61:30];
    pl_r   <= 64'(cr_r[19].a[31:0]) * 64'(bsel);
    ph_r   <= 61'(cr_r[19].a[60:32]) * 61'(bsel);
    pw_r   <= 93'(pl_r) + (93'(ph_r) << 32);
    sub_r  <= (cr_r[20].kind == nsf_pkg::KIND_EXP) ? (91'(cr_r[20].a) << 30) : '0;
    shv_r  <= SW'(pw_r) << ((cr_r[21].kind == nsf_pkg::KIND_EXP) ? cr_r[21].k : 6'd0);
    sub2_r <= sub_r;
    w_r    <= shv_r - SW'(sub2_r);
  end

  always_comb begin
    logic [MW-1:0] mag;
    logic [FW-1:0] f;
    logic          sat;
    car_t          c;
    c = cr_r[NST];
    if (c.kind == nsf_pkg::KIND_EXP && c.mode == nsf_pkg::MODE_COLLAGEN) begin
      mag = MW'(w_r >> 38);
    end else if (c.kind == nsf_pkg::KIND_EXP) begin
      mag = MW'(w_r >> 22);
    end else begin
      mag = MW'(w_r >> 20);
    end
    f   = '0;
    sat = 1'b0;
    case (c.kind)
      nsf_pkg::KIND_NEG: begin
        if (mag > NEG_LIM) begin
          f   = NEG_LIM[FW-1:0];
          sat = 1'b1;
        end else begin
          f = '0 - mag[FW-1:0];
        end
      end
      nsf_pkg::KIND_LIN: begin
        if (mag > POS_LIM) begin
          f   = POS_LIM[FW-1:0];
          sat = 1'b1;
        end else begin
          f = mag[FW-1:0];
        end
      end
      nsf_pkg::KIND_EXP: begin
        if (c.ovf) begin
          f   = c.kappa_nz ? POS_LIM[FW-1:0] : '0;
          sat = c.kappa_nz;
        end else if (mag > POS_LIM) begin
          f   = POS_LIM[FW-1:0];
          sat = 1'b1;
        end else begin
          f = mag[FW-1:0];
        end
      end
      default: begin
        f   = '0;
        sat = 1'b0;
      end
    endcase
    out_force_r_nxt = 64'(signed'(f));
    out_sat_nxt     = sat || c.clip_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cr_r[NST].vld;
    end
    out_force_r <= out_force_r_nxt;
    out_sat_r   <= out_sat_nxt;
    out_bad_r   <= cr_r[NST].bad;
  end

  assign out_valid     = out_valid_r;
  assign out_force_res = out_force_r;
  assign out_saturated = out_sat_r;
  assign out_bad_rest  = out_bad_r;

endmodule

// File: hdl/nonlinear_spring_force_law.sv
`timescale 1ns / 1ps
// Spring force unit: one spring item is accepted per clock while busy is low, and
// each result is shown on the out_ ports for one cycle with out_valid high. The
// path runs through the 32-step strain divider (one quotient bit per stage) and
// through the exp unit with its seven-step polynomial, two stages a step. Results
// come out in input order and cannot be held off; busy only rises if the queue
// between divider and force stages fills, which a steady one-per-cycle stream
// does not cause.
module nonlinear_spring_force_law #(
  parameter int LENGTH_WIDTH = 32,
  parameter int FORCE_WIDTH  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_length,
  input  logic [31:0] in_rest_length,
  input  logic [31:0] in_stiffness,
  output logic        out_valid,
  output logic [63:0] out_force_res,
  output logic        out_saturated,
  output logic        out_bad_rest
);

  localparam int LW_EFF = (LENGTH_WIDTH < 32) ? LENGTH_WIDTH : 32;

  nsf_pkg::item_t f_item, q_item;
  logic           f_push, q_empty, q_full;

  nsf_front #(.LW(LW_EFF)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_mode        (in_mode),
    .in_length      (in_length),
    .in_rest_length (in_rest_length),
    .in_stiffness   (in_stiffness),
    .busy           (busy),
    .push           (f_push),
    .item           (f_item),
    .full           (q_full)
  );

  nsf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_item),
    .pop   (!q_empty),
    .dout  (q_item),
    .empty (q_empty),
    .full  (q_full)
  );

  nsf_back #(.FW(FORCE_WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .item          (q_item),
    .item_vld      (!q_empty),
    .out_valid     (out_valid),
    .out_force_res (out_force_res),
    .out_saturated (out_saturated),
    .out_bad_rest  (out_bad_rest)
  );

  a_bad_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_bad_rest |-> !out_saturated)
    else $error("zero rest length item flagged saturated");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_bad_rest |-> out_force_res == '0)
    else $error("zero rest length item with nonzero force");
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

// File: tb/sv/tb_nonlinear_spring_force_law.sv
`timescale 1ns / 1ps
module tb_nonlinear_spring_force_law;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;

  typedef struct {
    logic [63:0] force_res;
    logic        saturated;
    logic        bad_rest;
  } spring_force_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = '0;
  logic [31:0] in_length = '0;
  logic [31:0] in_rest_length = '0;
  logic [31:0] in_stiffness = '0;
  logic        out_valid;
  logic [63:0] out_force_res;
  logic        out_saturated;
  logic        out_bad_rest;

  spring_force_t expected_forces[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  nonlinear_spring_force_law u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_length(in_length), .in_rest_length(in_rest_length),
    .in_stiffness(in_stiffness), .out_valid(out_valid), .out_force_res(out_force_res),
    .out_saturated(out_saturated), .out_bad_rest(out_bad_rest)
  );

  always #5 clk = ~clk;

  function automatic logic [127:0] mul128(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wa;
    logic [127:0] wb;
    wa = {64'd0, a};
    wb = {64'd0, b};
    return wa * wb;
  endfunction

  function automatic logic [63:0] clip_scale(input logic [63:0] kc, input logic [127:0] v,
                                             input int sh, input logic [63:0] limit,
                                             inout logic sat);
    logic [191:0] prod;
    logic [191:0] raw;
    prod = {64'd0, kc} * {64'd0, v};
    raw = prod >> sh;
    if (raw > {128'd0, limit}) begin
      sat = 1'b1;
      return limit;
    end
    return raw[63:0];
  endfunction

  function automatic logic expm1_q30(input logic [63:0] x, output logic [127:0] res);
    logic [127:0] t;
    logic [63:0] y, k, f, g, z, p, m;
    logic [63:0] tq [4];
    tq[0] = 64'd1073741824; tq[1] = 64'd1276901417;
    tq[2] = 64'd1518500250; tq[3] = 64'd1805811301;
    t = mul128(x, 64'd1549082005);
    y = t[93:30];
    k = y >> 28;
    res = '0;
    if (k >= 64) return 1'b1;
    f = y & 64'h0FFF_FFFF;
    g = f & 64'h03FF_FFFF;
    z = ((g << 2) * 64'd744261118) >> 30;
    p = 64'd1073741824;
    for (int n = 7; n >= 1; n--) p = 64'd1073741824 + ((z * p) >> 30) / n;
    m = (tq[f[27:26]] * p) >> 30;
    res = ({64'd0, m} << k) - 128'd1073741824;
    return 1'b0;
  endfunction

  function automatic spring_force_t predict_force(input logic [1:0] mode,
      input logic [31:0] len, input logic [31:0] rest, input logic [31:0] kappa);
    spring_force_t o;
    logic [63:0] qi, r, frac, force_v, rate, x, kc;
    logic signed [63:0] e;
    logic [127:0] v;
    logic sat, clip;
    int sh;
    o.force_res = '0; o.saturated = 1'b0; o.bad_rest = 1'b0;
    sat = 1'b0; clip = 1'b0; force_v = '0; frac = '0;
    if (rest == 0) begin
      o.bad_rest = 1'b1;
      return o;
    end
    qi = len / rest;
    if (qi >= 9) begin
      e = 64'sd2147483647;
      clip = 1'b1;
    end else begin
      r = len % rest;
      for (int i = 0; i < 28; i++) begin
        r = r << 1;
        frac = frac << 1;
        if (r >= rest) begin
          r = r - rest;
          frac[0] = 1'b1;
        end
      end
      e = $signed((qi << 28) + frac) - 64'sd268435456;
    end
    if (mode == nsf_pkg::MODE_COMP) begin
      if (e < 0) begin
        force_v = clip_scale({32'd0, kappa}, {64'd0, -e}, 20, 64'h8000_0000_0000_0000, sat);
        force_v = 64'd0 - force_v;
      end
    end else if (mode == nsf_pkg::MODE_COLLAGEN && e > 64'sd38923141) begin
      force_v = clip_scale({32'd0, kappa} * 64'd325000000, {64'd0, e - 64'sd33554432}, 20,
                           64'h7FFF_FFFF_FFFF_FFFF, sat);
    end else if (e > 0) begin
      rate = mode == nsf_pkg::MODE_COLLAGEN ? 64'd838261853 :
             (mode == nsf_pkg::MODE_CIRC ? 64'd963960269 : 64'd375762664);
      x = (e * rate) >> 24;
      kc = mode == nsf_pkg::MODE_COLLAGEN ? {32'd0, kappa} * 64'd304309862 : {32'd0, kappa};
      sh = mode == nsf_pkg::MODE_COLLAGEN ? 38 : 22;
      if (expm1_q30(x, v)) begin
        if (kappa != 0) begin
          force_v = 64'h7FFF_FFFF_FFFF_FFFF;
          sat = 1'b1;
        end
      end else begin
        force_v = clip_scale(kc, v, sh, 64'h7FFF_FFFF_FFFF_FFFF, sat);
      end
    end
    if (clip && mode != nsf_pkg::MODE_COMP && kappa != 0) sat = 1'b1;
    o.force_res = force_v;
    o.saturated = sat;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    spring_force_t w;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_forces.size() == 0) begin
        report_mismatch("unexpected result", out_force_res, 64'd0);
      end else begin
        w = expected_forces.pop_front();
        if (out_force_res !== w.force_res) report_mismatch("force", out_force_res, w.force_res);
        if (out_saturated !== w.saturated)
          report_mismatch("saturated", {63'd0, out_saturated}, {63'd0, w.saturated});
        if (out_bad_rest !== w.bad_rest)
          report_mismatch("bad_rest", {63'd0, out_bad_rest}, {63'd0, w.bad_rest});
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("nonlinear_spring_force_law regression: fail");
      $finish;
    end
  end

  task automatic send_spring(input logic [1:0] mode, input logic [31:0] len,
                             input logic [31:0] rest, input logic [31:0] kappa,
                             input bit paced);
    if (paced) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        if ($urandom_range(0, 2) != 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      burst_left--;
    end
    start <= 1'b1;
    in_mode <= mode;
    in_length <= len;
    in_rest_length <= rest;
    in_stiffness <= kappa;
    expected_forces.push_back(predict_force(mode, len, rest, kappa));
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic test_directed;
    logic [31:0] one;
    one = 32'h0010_0000;
    for (int m = 0; m < 4; m++) begin
      send_spring(m[1:0], one, 32'd0, 32'h0001_0000, 1'b0);
      send_spring(m[1:0], one >> 1, one, 32'h0001_0000, 1'b0);
      send_spring(m[1:0], one + (one >> 3), one, 32'hFFFF_FFFF, 1'b0);
      send_spring(m[1:0], 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1'b0);
      send_spring(m[1:0], 32'hFFFF_FFFF, 32'd1, 32'd0, 1'b0);
    end
    send_spring(nsf_pkg::MODE_COLLAGEN, 32'd1145, 32'd1000, 32'h0001_0000, 1'b0);
    send_spring(nsf_pkg::MODE_COLLAGEN, 32'd1146, 32'd1000, 32'h0001_0000, 1'b0);
    send_spring(nsf_pkg::MODE_CIRC, 32'd8000, 32'd1000, 32'hFFFF_FFFF, 1'b0);
    send_spring(nsf_pkg::MODE_COMP, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_spring(nsf_pkg::MODE_RADIAL, one, one, 32'h1234_5678, 1'b0);
    start <= 1'b0;
  endtask

  task automatic test_random;
    logic [31:0] rest, len;
    for (int i = 0; i < 750; i++) begin
      rest = $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(1, 32'h0100_0000);
      case ($urandom_range(0, 4))
        0: len = $urandom();
        1: len = rest + rest / $urandom_range(1, 50);
        2: len = rest - rest / $urandom_range(1, 50);
        3: len = rest * $urandom_range(1, 12);
        default: len = rest + $urandom_range(0, 255);
      endcase
      if ($urandom_range(0, 30) == 0) rest = 0;
      send_spring(2'($urandom_range(0, 3)), len, rest,
                  $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h0004_0000), 1'b1);
    end
    start <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d spring items over all four laws, checked %0d results",
             items_sent, results_seen);
    if (errors == 0) $display("nonlinear_spring_force_law regression: pass");
    else $display("nonlinear_spring_force_law regression: fail");
    $finish;
  end
endmodule

// File: nonlinear_spring_force_law.f
hdl/nsf_pkg.sv
hdl/nsf_front.sv
hdl/nsf_queue.sv
hdl/nsf_back.sv
hdl/nonlinear_spring_force_law.sv
tb/sv/tb_nonlinear_spring_force_law.sv
